// ----- hw/rtl/anb_pkg.sv -----
// ============================================================================
// anb_pkg - shared types for the Annex B unit splitter
// Word layouts of both channels, the parser state and the sizes of the
// result queue.
// ============================================================================
package anb_pkg;

    // Byte values that drive the start code search.
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [7:0] ONE_BYTE  = 8'h01;
    localparam logic [4:0] TYPE_MASK = 5'h1f;

    // Zero run counter saturates here.
    localparam logic [1:0] ZERO_RUN_MAX = 2'd3;

    // One input byte causes at most this many result words.
    localparam int MAX_BURST = 5;
    localparam int BURST_CW  = $clog2(MAX_BURST + 1);

    // Result queue.
    localparam int FIFO_AW    = 3;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_word;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       unit_first;
        logic       unit_last;
        logic [4:0] unit_type;
    } t_out_word;

    typedef struct packed {
        logic       inside_unit;
        logic [1:0] zero_run;
        logic       held_valid;
        logic [7:0] held_byte;
        logic       held_is_first;
        logic [4:0] current_type;
    } t_parse_state;

    typedef struct packed {
        t_parse_state st;
        logic         emit;
        t_out_word    word;
    } t_push_result;

endpackage

// ----- hw/rtl/annexb_nal_unit_splitter.sv -----
// ============================================================================
// annexb_nal_unit_splitter - H.264 Annex B start code parser
// Strips start codes from a byte stream and tags every payload byte with
// unit first / last marks and the unit type.
// ============================================================================
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-----------------------------
//  input   | in        | i_valid / o_stall   | i_data : anb_pkg::t_in_word
//  output  | out       | o_valid / i_stall   | o_data : anb_pkg::t_out_word
//
// One byte is accepted per cycle unless the input stalls. An accepted byte
// passes through the input register, where the parser works out up to five
// result words and writes them into an eight-word result queue; the first
// of them shows at the output once it is in the queue. The input stalls
// only while the queue lacks room for a full five-word burst. Reset is
// synchronous and active low and empties both the input register and the
// queue. A stall on the output holds the word at the head of the queue.
//
module annexb_nal_unit_splitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  anb_pkg::t_in_word i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output anb_pkg::t_out_word o_data
);
    import anb_pkg::*;

    // Input register.
    logic         r_in_valid;
    t_in_word     r_in;

    // Parser state.
    t_parse_state r_st;
    t_parse_state n_st;

    // Burst of result words produced by the byte in the input register.
    t_out_word    w_ent [MAX_BURST];
    logic [BURST_CW-1:0] w_cnt;

    // Result queue.
    t_out_word    r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;

    logic w_proc;
    logic w_pop;

    // A payload byte enters the open unit. The byte held back so far is
    // released, since it is now known not to be the unit's last one, and
    // the new byte takes its place. Outside a unit the byte is dropped.
    function automatic t_push_result push_fn(t_parse_state st, logic [7:0] v);
        t_push_result r;
        r.st   = st;
        r.emit = 1'b0;
        r.word = '0;
        if (st.inside_unit) begin
            if (st.held_valid) begin
                r.emit              = 1'b1;
                r.word.payload_byte = st.held_byte;
                r.word.unit_first   = st.held_is_first;
                r.word.unit_last    = 1'b0;
                r.word.unit_type    = st.current_type;
            end else begin
                r.st.current_type = v[4:0] & TYPE_MASK;
            end
            r.st.held_byte     = v;
            r.st.held_is_first = !st.held_valid;
            r.st.held_valid    = 1'b1;
        end
        return r;
    endfunction

    // The queue must have room for the largest burst before a byte is parsed.
    assign w_proc  = r_in_valid && (r_count <= FIFO_CW'(FIFO_DEPTH - MAX_BURST));
    assign o_stall = r_in_valid && !w_proc;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && !i_stall;

    // Parser step for the byte in the input register.
    always_comb begin : parse
        t_parse_state        v_st;
        t_push_result        v_pr;
        logic [BURST_CW-1:0] v_cnt;
        v_st  = r_st;
        v_cnt = '0;
        v_pr  = '0;
        for (int i = 0; i < MAX_BURST; i++) begin
            w_ent[i] = '0;
        end

        if (r_in.data_byte == ZERO_BYTE) begin
            if (v_st.zero_run == ZERO_RUN_MAX) begin
                // A fourth zero pushes the oldest pending zero into the unit.
                v_pr = push_fn(v_st, ZERO_BYTE);
                v_st = v_pr.st;
                if (v_pr.emit) begin
                    w_ent[v_cnt] = v_pr.word;
                    v_cnt        = v_cnt + 1'b1;
                end
            end else begin
                v_st.zero_run = v_st.zero_run + 1'b1;
            end
        end else if (r_in.data_byte == ONE_BYTE && v_st.zero_run >= 2'd2) begin
            // Start code: close the open unit, then open a new one.
            if (v_st.inside_unit && v_st.held_valid) begin
                w_ent[v_cnt].payload_byte = v_st.held_byte;
                w_ent[v_cnt].unit_first   = v_st.held_is_first;
                w_ent[v_cnt].unit_last    = 1'b1;
                w_ent[v_cnt].unit_type    = v_st.current_type;
                v_cnt                     = v_cnt + 1'b1;
            end
            v_st.held_valid    = 1'b0;
            v_st.held_is_first = 1'b0;
            v_st.inside_unit   = 1'b1;
            v_st.zero_run      = '0;
        end else begin
            // Pending zeros were payload after all, then the byte itself.
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < r_st.zero_run) begin
                    v_pr = push_fn(v_st, ZERO_BYTE);
                    v_st = v_pr.st;
                    if (v_pr.emit) begin
                        w_ent[v_cnt] = v_pr.word;
                        v_cnt        = v_cnt + 1'b1;
                    end
                end
            end
            v_st.zero_run = '0;
            v_pr = push_fn(v_st, r_in.data_byte);
            v_st = v_pr.st;
            if (v_pr.emit) begin
                w_ent[v_cnt] = v_pr.word;
                v_cnt        = v_cnt + 1'b1;
            end
        end

        if (r_in.end_of_stream) begin
            // End of stream: pending zeros become payload, the held byte
            // closes the unit and the parser starts over.
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < v_st.zero_run) begin
                    v_pr = push_fn(v_st, ZERO_BYTE);
                    v_st = v_pr.st;
                    if (v_pr.emit) begin
                        w_ent[v_cnt] = v_pr.word;
                        v_cnt        = v_cnt + 1'b1;
                    end
                end
            end
            if (v_st.inside_unit && v_st.held_valid) begin
                w_ent[v_cnt].payload_byte = v_st.held_byte;
                w_ent[v_cnt].unit_first   = v_st.held_is_first;
                w_ent[v_cnt].unit_last    = 1'b1;
                w_ent[v_cnt].unit_type    = v_st.current_type;
                v_cnt                     = v_cnt + 1'b1;
            end
            v_st = '0;
        end

        n_st  = v_st;
        w_cnt = v_cnt;
    end

    // Input register and parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st       <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (w_proc) begin
                r_st <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    // Result queue storage: a burst lands in consecutive free slots.
    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            for (int i = 0; i < MAX_BURST; i++) begin
                if (BURST_CW'(i) < w_cnt) begin
                    r_mem[r_wr_ptr + FIFO_AW'(i)] <= w_ent[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_proc) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(w_cnt);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (w_proc ? FIFO_CW'(w_cnt) : FIFO_CW'(0))
                       - FIFO_CW'(w_pop);
        end
    end

endmodule

// ----- hw/rtl/anb_checker.sv -----
// ============================================================================
// anb_checker - port level checks for the Annex B unit splitter
// Watches the output channel for handshake and unit framing rules, and both channels after reset.
// ============================================================================
module anb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input anb_pkg::t_out_word o_data
);
    import anb_pkg::*;

    logic       w_out_acc;
    logic       r_open;
    logic [4:0] r_type;

    assign w_out_acc = o_valid && !i_stall;

    // Tracks whether the last word taken left a unit open, and its type.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_type <= '0;
        end else if (w_out_acc) begin
            r_open <= !o_data.unit_last;
            r_type <= o_data.unit_type;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled output word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs active right after reset");

    a_header_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.unit_first |->
            o_data.unit_type == (o_data.payload_byte[4:0] & TYPE_MASK))
        else $error("unit type differs from header byte");

    a_framing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (r_open ? (!o_data.unit_first && o_data.unit_type == r_type)
                              : o_data.unit_first))
        else $error("unit framing broken");

endmodule

bind annexb_nal_unit_splitter anb_checker u_anb_checker (.*);
